FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the cartridge bank mapper core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: hw/rtl/cbm_pkg.sv
// Types and constants of the cartridge bank mapper.
package cbm_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CART_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_CODE  = 1'd1;

    localparam logic [7:0] CART_ROM_ONLY = 8'd0;
    localparam logic [7:0] CART_MBC1_LO  = 8'd1;
    localparam logic [7:0] CART_MBC1_HI  = 8'd3;

    localparam logic [7:0] RAM_SZ_8K  = 8'd2;
    localparam logic [7:0] RAM_SZ_32K = 8'd3;

    localparam logic [15:0] ADDR_RAMEN_END   = 16'h1FFF;
    localparam logic [15:0] ADDR_ROMBANK_END = 16'h3FFF;
    localparam logic [15:0] ADDR_RAMBANK_END = 16'h5FFF;
    localparam logic [15:0] ADDR_ROM_END     = 16'h7FFF;
    localparam logic [15:0] ADDR_RAM_LO      = 16'hA000;
    localparam logic [15:0] ADDR_RAM_HI      = 16'hBFFF;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;

    typedef enum logic [1:0] {
        SRC_ROM   = 2'd0,
        SRC_RAM   = 2'd1,
        SRC_OPEN  = 2'd2,
        SRC_WRITE = 2'd3
    } t_src;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_item;

    typedef struct packed {
        t_src        src;
        logic [18:0] rom_address;
        logic [7:0]  read_data;
        logic        fault;
    } t_resp;

    typedef struct packed {
        logic        wr;
        logic        rd;
        logic [1:0]  bank;
        logic [12:0] offset;
        logic [7:0]  wdata;
    } t_ram_req;

endpackage

FILE: hw/rtl/cbm_in_if.sv
// Bus access channel of the cartridge bank mapper.
interface cbm_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, mode, address, write_data, input ready);
    modport sink (input valid, mode, address, write_data, output ready);
endinterface

FILE: hw/rtl/cbm_out_if.sv
// Result channel of the cartridge bank mapper.
interface cbm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  src;
    logic [18:0] rom_address;
    logic [7:0]  read_data;
    logic        fault;

    modport source (output valid, src, rom_address, read_data, fault, input ready);
    modport sink (input valid, src, rom_address, read_data, fault, output ready);
endinterface

FILE: hw/rtl/cbm_ctrl.sv
// Configuration and bank registers, access decode and ROM address mapping.
module cbm_ctrl
    import cbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_accept,
    input  t_item                 i_item,
    output t_resp                 o_resp,
    output t_ram_req              o_ram_req
);

    logic [7:0] r_cart_type;
    logic [7:0] r_ram_code;
    logic       r_ram_en;
    logic [4:0] r_rom_sel;
    logic [1:0] r_ram_sel;

    logic       w_is_mbc;
    logic       w_in_win;
    logic       w_ram_ok;
    logic [4:0] w_bank_eff;

    assign w_is_mbc   = r_cart_type inside {[CART_MBC1_LO:CART_MBC1_HI]};
    assign w_in_win   = i_item.address inside {[ADDR_RAM_LO:ADDR_RAM_HI]};
    assign w_ram_ok   = r_ram_en && (r_ram_code == RAM_SZ_8K || r_ram_code == RAM_SZ_32K);
    assign w_bank_eff = (r_rom_sel == 5'd0) ? 5'd1 : r_rom_sel;

    always_comb begin
        o_resp = '{src: SRC_OPEN, rom_address: '0, read_data: OPEN_BUS, fault: 1'b0};
        o_ram_req.wr     = 1'b0;
        o_ram_req.rd     = 1'b0;
        o_ram_req.bank   = (r_ram_code == RAM_SZ_32K) ? r_ram_sel : 2'd0;
        o_ram_req.offset = i_item.address[12:0];
        o_ram_req.wdata  = i_item.write_data;
        if (r_cart_type == CART_ROM_ONLY) begin
            o_resp.read_data = '0;
            if (i_item.mode) begin
                o_resp.src = SRC_WRITE;
            end else begin
                o_resp.src         = SRC_ROM;
                o_resp.rom_address = {3'b000, i_item.address};
            end
        end else if (w_is_mbc) begin
            if (i_item.mode) begin
                o_resp.src       = SRC_WRITE;
                o_resp.read_data = '0;
                o_ram_req.wr     = i_accept && w_in_win && w_ram_ok;
            end else if (i_item.address <= ADDR_ROMBANK_END) begin
                o_resp.src         = SRC_ROM;
                o_resp.rom_address = {3'b000, i_item.address};
                o_resp.read_data   = '0;
            end else if (i_item.address <= ADDR_ROM_END) begin
                o_resp.src         = SRC_ROM;
                o_resp.rom_address = {w_bank_eff, i_item.address[13:0]};
                o_resp.read_data   = '0;
            end else if (w_in_win && w_ram_ok) begin
                o_resp.src   = SRC_RAM;
                o_ram_req.rd = i_accept;
            end
        end else begin
            o_resp.fault = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_type <= '0;
            r_ram_code  <= '0;
            r_ram_en    <= 1'b0;
            r_rom_sel   <= '0;
            r_ram_sel   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CART_TYPE: r_cart_type <= i_cfg_wdata;
                    CFG_RAM_CODE:  r_ram_code  <= i_cfg_wdata;
                    default:       r_ram_code  <= r_ram_code;
                endcase
            end
            if (i_accept && w_is_mbc && i_item.mode) begin
                if (i_item.address <= ADDR_RAMEN_END) begin
                    r_ram_en <= (i_item.write_data[3:0] == RAM_EN_KEY);
                end else if (i_item.address <= ADDR_ROMBANK_END) begin
                    r_rom_sel <= i_item.write_data[4:0];
                end else if (i_item.address <= ADDR_RAMBANK_END) begin
                    r_ram_sel <= i_item.write_data[1:0];
                end
            end
        end
    end

endmodule

FILE: hw/rtl/cbm_ram.sv
// External cartridge RAM with bank to index mapping and registered read.
module cbm_ram
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES = 32768
)
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output logic [7:0] o_rdata
);

    localparam int AW = $clog2(RAM_BYTES);
    localparam logic [AW-1:0] BANK_OFS [4] = '{
        AW'(0),
        AW'(8192 % RAM_BYTES),
        AW'(16384 % RAM_BYTES),
        AW'(24576 % RAM_BYTES)
    };

    logic [7:0]    r_mem [RAM_BYTES];
    logic [7:0]    r_rdata;
    logic [AW:0]   w_sum;
    logic [AW:0]   w_wrap;
    logic [AW-1:0] w_idx;

    // offset < 8KB <= depth, so one subtract wraps the sum
    assign w_sum  = (AW+1)'(i_req.offset) + (AW+1)'(BANK_OFS[i_req.bank]);
    assign w_wrap = (w_sum >= (AW+1)'(RAM_BYTES)) ? w_sum - (AW+1)'(RAM_BYTES) : w_sum;
    assign w_idx  = w_wrap[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[w_idx] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[w_idx];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/cartridge_bank_mapper_core.sv
// Cartridge bank mapper: one result for each bus read or write transfer. ROM
// reads, open-bus reads and writes of any kind load their result straight into
// the output register, so such transfers are taken on every cycle while the
// result side keeps up. A read of the external RAM window first passes through
// the registered read of the RAM, a single-port memory, and no new transfer is
// taken while its read is outstanding. A result waits in an output register,
// and the next transfer is taken in the cycle that this register drains. RAM
// contents are not cleared at reset; a byte reads back valid once written.
// Configuration writes (cartridge type, RAM size) take effect on the next cycle.
`include "assert_macros.svh"
module cartridge_bank_mapper_core
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES = 32768
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    cbm_in_if.sink                i_req,
    cbm_out_if.source             o_rsp
);

    t_item    w_item;
    t_resp    w_resp;
    t_ram_req w_ram_req;
    logic [7:0] w_ram_rdata;
    logic     w_accept;
    logic     w_drain;

    logic     r_rd_pend;
    logic     n_rd_pend;
    logic     r_out_valid;
    logic     n_out_valid;
    t_resp    r_out;
    t_resp    n_out;

    assign w_item  = '{mode: i_req.mode, address: i_req.address,
                       write_data: i_req.write_data};
    assign w_drain = r_out_valid && o_rsp.ready;

    assign i_req.ready = !r_rd_pend && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    cbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_item      (w_item),
        .o_resp      (w_resp),
        .o_ram_req   (w_ram_req)
    );

    cbm_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_rd_pend   = 1'b0;
        n_out_valid = r_out_valid && !w_drain;
        n_out       = r_out;
        if (r_rd_pend) begin
            n_out_valid = 1'b1;
            n_out       = '{src: SRC_RAM, rom_address: '0, read_data: w_ram_rdata,
                            fault: 1'b0};
        end else if (w_accept) begin
            if (w_ram_req.rd) begin
                n_rd_pend = 1'b1;
            end else begin
                n_out_valid = 1'b1;
                n_out       = w_resp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.src         = r_out.src;
    assign o_rsp.rom_address = r_out.rom_address;
    assign o_rsp.read_data   = r_out.read_data;
    assign o_rsp.fault       = r_out.fault;

    `ASSERT_PROP(a_rd_sets_pend, i_clk, i_rst_n, w_ram_req.rd |=> r_rd_pend, "RAM read lost")
    `ASSERT_PROP(a_pend_one_cycle, i_clk, i_rst_n, r_rd_pend |=> !r_rd_pend && r_out_valid, "RAM read result not loaded")
    `ASSERT_PROP(a_fault_open, i_clk, i_rst_n, o_rsp.valid && o_rsp.fault |-> o_rsp.src == SRC_OPEN && o_rsp.rom_address == 19'd0, "fault result not open bus")
    `ASSERT_NEVER(a_rd_wr_excl, i_clk, i_rst_n, w_ram_req.rd && w_ram_req.wr, "RAM read and write together")

endmodule

FILE: test/tb.sv
// Self-checking testbench for the cartridge bank mapper core.
`timescale 1ns / 100ps

import cbm_pkg::*;

localparam logic BUS_READ  = 1'b0;
localparam logic BUS_WRITE = 1'b1;

class mapper_scoreboard #(int unsigned DEPTH = 32768);
    logic [7:0] cart_type;
    logic [7:0] ram_code;
    bit         ram_en;
    bit   [4:0] rom_sel;
    bit   [1:0] ram_sel;
    bit   [7:0] ram_byte [DEPTH];
    bit         ram_valid [DEPTH];
    t_resp      pending_results [$];
    int         n_errors;
    int         n_checked;
    int         n_rom, n_ram, n_open, n_write, n_fault;

    function new();
        cart_type = CART_ROM_ONLY;
        ram_code  = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        if (idx == CFG_CART_TYPE) begin
            cart_type = value;
        end else begin
            ram_code = value;
        end
    endfunction

    function bit is_mbc1();
        return cart_type >= CART_MBC1_LO && cart_type <= CART_MBC1_HI;
    endfunction

    function bit ram_slot(logic [15:0] addr, output int unsigned slot);
        int unsigned off;
        off  = addr - ADDR_RAM_LO;
        slot = 0;
        if (!ram_en) return 0;
        if (ram_code == RAM_SZ_8K) begin
            slot = off % DEPTH;
            return 1;
        end
        if (ram_code == RAM_SZ_32K) begin
            slot = (off + 32'h2000 * ram_sel) % DEPTH;
            return 1;
        end
        return 0;
    endfunction

    function bit in_window(logic [15:0] addr);
        return addr >= ADDR_RAM_LO && addr <= ADDR_RAM_HI;
    endfunction

    // True when a read would return a RAM byte that was never stored.
    function bit reads_unwritten(t_item it);
        int unsigned slot;
        if (!is_mbc1() || it.mode != BUS_READ || !in_window(it.address)) return 0;
        if (!ram_slot(it.address, slot)) return 0;
        return !ram_valid[slot];
    endfunction

    function void apply_access(t_item it);
        t_resp       r;
        int unsigned slot;
        int unsigned bank;
        r.src         = SRC_OPEN;
        r.rom_address = '0;
        r.read_data   = OPEN_BUS;
        r.fault       = 1'b0;
        if (cart_type == CART_ROM_ONLY) begin
            r.read_data = '0;
            if (it.mode == BUS_WRITE) begin
                r.src = SRC_WRITE;
            end else begin
                r.src         = SRC_ROM;
                r.rom_address = 19'(it.address);
            end
        end else if (is_mbc1()) begin
            if (it.mode == BUS_WRITE) begin
                r.src       = SRC_WRITE;
                r.read_data = '0;
                if (it.address <= ADDR_RAMEN_END) begin
                    ram_en = (it.write_data[3:0] == RAM_EN_KEY);
                end else if (it.address <= ADDR_ROMBANK_END) begin
                    rom_sel = it.write_data[4:0];
                end else if (it.address <= ADDR_RAMBANK_END) begin
                    ram_sel = it.write_data[1:0];
                end else if (in_window(it.address) && ram_slot(it.address, slot)) begin
                    ram_byte[slot]  = it.write_data;
                    ram_valid[slot] = 1'b1;
                end
            end else if (it.address <= ADDR_ROMBANK_END) begin
                r.src         = SRC_ROM;
                r.rom_address = 19'(it.address);
                r.read_data   = '0;
            end else if (it.address <= ADDR_ROM_END) begin
                bank          = (rom_sel == 0) ? 1 : rom_sel;
                r.src         = SRC_ROM;
                r.rom_address = 19'(it.address + 32'h4000 * (bank - 1));
                r.read_data   = '0;
            end else if (in_window(it.address) && ram_slot(it.address, slot)) begin
                r.src       = SRC_RAM;
                r.read_data = ram_byte[slot];
            end
        end else begin
            r.fault = 1'b1;
        end
        case (r.src)
            SRC_ROM:   n_rom++;
            SRC_RAM:   n_ram++;
            SRC_OPEN:  n_open++;
            default:   n_write++;
        endcase
        if (r.fault) n_fault++;
        pending_results.push_back(r);
    endfunction

    function void check_result(t_resp got);
        t_resp exp;
        if (pending_results.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("%0t: result with nothing pending: src %0d rom %05h data %02h fault %0b",
                         $realtime, got.src, got.rom_address, got.read_data, got.fault);
            return;
        end
        exp = pending_results.pop_front();
        n_checked++;
        if (got.src !== exp.src || got.rom_address !== exp.rom_address ||
            got.read_data !== exp.read_data || got.fault !== exp.fault) begin
            n_errors++;
            if (n_errors <= 10)
                $display({"%0t: mismatch: exp src %0d rom %05h data %02h fault %0b, ",
                          "got src %0d rom %05h data %02h fault %0b"}, $realtime,
                         exp.src, exp.rom_address, exp.read_data, exp.fault,
                         got.src, got.rom_address, got.read_data, got.fault);
        end
    endfunction
endclass

module tb;
    localparam int RAM_BYTES   = 32768;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 62;
    localparam int HOLD_CYCLES = 150;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    cbm_in_if  bus_if ();
    cbm_out_if rsp_if ();

    cartridge_bank_mapper_core #(
        .RAM_BYTES (RAM_BYTES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (bus_if),
        .o_rsp       (rsp_if)
    );

    mapper_scoreboard #(RAM_BYTES) sb;

    int src_idle_pct;
    int dst_stall_pct;
    bit hold_armed;
    bit hold_done;
    int hold_left;

    int phase_cart [N_PHASES] = '{1, 2, 3, 0, 1, 255, 3, 2, 4, 1};
    int phase_ram  [N_PHASES] = '{3, 2, 3, 0, 2, 255, 0, 3, 1, 3};
    int phase_idle [N_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 3};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(200_000 * 10);
        $display("Test completed with failures");
        $finish;
    end

    // Result side: check every transfer, then pick next cycle's ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result('{src: t_src'(rsp_if.src), rom_address: rsp_if.rom_address,
                                  read_data: rsp_if.read_data, fault: rsp_if.fault});
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !(dst_stall_pct != 0 && $urandom_range(0, 99) < dst_stall_pct);
            end
        end
    end

    task automatic send_item(input t_item it);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            bus_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        bus_if.valid      <= 1'b1;
        bus_if.mode       <= it.mode;
        bus_if.address    <= it.address;
        bus_if.write_data <= it.write_data;
        @(posedge i_clk);
        while (!bus_if.ready) @(posedge i_clk);
        sb.apply_access(it);
    endtask

    task automatic send(input logic mode, input logic [15:0] addr, input logic [7:0] data);
        send_item('{mode: mode, address: addr, write_data: data});
    endtask

    task automatic drain();
        bus_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [7:0] cart, input logic [7:0] ram_sz);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_CART_TYPE;
        i_cfg_wdata <= cart;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_RAM_CODE;
        i_cfg_wdata <= ram_sz;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.set_reg(CFG_CART_TYPE, cart);
        sb.set_reg(CFG_RAM_CODE, ram_sz);
    endtask

    function automatic logic [15:0] ram_window_addr();
        case ($urandom_range(0, 3))
            0:       return ADDR_RAM_LO + 16'($urandom_range(0, 16'h1FFF));
            1:       return ADDR_RAM_HI - 16'($urandom_range(0, 7));
            default: return ADDR_RAM_LO + 16'($urandom_range(0, 7));
        endcase
    endfunction

    // Mostly well-formed MBC1 traffic: enable, bank selects, RAM and ROM accesses.
    function automatic t_item gen_access();
        t_item it;
        int    pick;
        pick          = $urandom_range(0, 99);
        it.mode       = BUS_WRITE;
        it.write_data = 8'($urandom_range(0, 255));
        it.address    = 16'($urandom_range(0, 16'hFFFF));
        if (pick < 10) begin
            it.address = 16'($urandom_range(0, ADDR_RAMEN_END));
            if ($urandom_range(0, 9) < 7) it.write_data[3:0] = RAM_EN_KEY;
        end else if (pick < 20) begin
            it.address = 16'($urandom_range(ADDR_RAMEN_END + 1, ADDR_ROMBANK_END));
        end else if (pick < 28) begin
            it.address = 16'($urandom_range(ADDR_ROMBANK_END + 1, ADDR_RAMBANK_END));
        end else if (pick < 31) begin
            it.address = 16'($urandom_range(ADDR_RAMBANK_END + 1, ADDR_ROM_END));
        end else if (pick < 46) begin
            it.mode    = BUS_READ;
            it.address = 16'($urandom_range(0, ADDR_ROMBANK_END));
        end else if (pick < 66) begin
            it.mode    = BUS_READ;
            it.address = 16'($urandom_range(ADDR_ROMBANK_END + 1, ADDR_ROM_END));
        end else if (pick < 81) begin
            it.address = ram_window_addr();
        end else if (pick < 96) begin
            it.mode    = BUS_READ;
            it.address = ram_window_addr();
        end else begin
            it.mode = 1'($urandom_range(0, 1));
        end
        if (sb.reads_unwritten(it)) it.mode = BUS_WRITE;
        return it;
    endfunction

    task automatic run_directed();
        load_config(CART_ROM_ONLY, 8'd0);
        send(BUS_READ, 16'h0000, 8'h00);
        send(BUS_READ, 16'hFFFF, 8'hFF);
        send(BUS_WRITE, 16'h2000, 8'h55);
        drain();
        load_config(CART_MBC1_LO, RAM_SZ_32K);
        send(BUS_WRITE, 16'h0000, 8'h0A);
        send(BUS_WRITE, 16'h2000, 8'h00);
        send(BUS_READ, 16'h4000, 8'h00);
        send(BUS_WRITE, 16'h3FFF, 8'h1F);
        send(BUS_READ, 16'h7FFF, 8'h00);
        send(BUS_READ, 16'h3FFF, 8'h00);
        send(BUS_WRITE, 16'h4000, 8'h03);
        send(BUS_WRITE, 16'hA000, 8'h5A);
        send(BUS_WRITE, 16'hBFFF, 8'hA5);
        send(BUS_READ, 16'hA000, 8'h00);
        send(BUS_READ, 16'hBFFF, 8'h00);
        send(BUS_WRITE, 16'h6000, 8'h01);
        send(BUS_READ, 16'h8000, 8'h00);
        send(BUS_READ, 16'hC000, 8'h00);
        send(BUS_WRITE, 16'hFFFF, 8'h12);
        send(BUS_WRITE, 16'h1FFF, 8'hF0);
        send(BUS_READ, 16'hA000, 8'h00);
        send(BUS_WRITE, 16'hA000, 8'h77);
        drain();
        load_config(8'hFF, RAM_SZ_32K);
        send(BUS_READ, 16'h4000, 8'h00);
        send(BUS_WRITE, 16'h0000, 8'h0A);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_wdata       = '0;
        bus_if.valid      = 1'b0;
        bus_if.mode       = BUS_READ;
        bus_if.address    = '0;
        bus_if.write_data = '0;
        rsp_if.ready      = 1'b0;
        src_idle_pct      = 0;
        dst_stall_pct     = 0;
        hold_armed        = 1'b0;
        hold_done         = 1'b0;
        hold_left         = 0;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            case (phase_idle[p])
                0: begin src_idle_pct = 0;  dst_stall_pct <= 0;  end
                1: begin src_idle_pct = 72; dst_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct <= 72; end
                default: begin src_idle_pct = 16; dst_stall_pct <= 16; end
            endcase
            load_config(8'(phase_cart[p]), 8'(phase_ram[p]));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) drain();
                if (p == 4 && k == 5) hold_armed <= 1'b1;
                send_item(gen_access());
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.pending_results.size() != 0) sb.n_errors++;
        $display("Checked %0d transfers over %0d register settings, with idle, stall and hold-off",
                 sb.n_checked, N_PHASES + 3);
        $display("phases; ROM %0d, RAM %0d, open bus %0d, writes %0d, faulted %0d; errors %0d",
                 sb.n_rom, sb.n_ram, sb.n_open, sb.n_write, sb.n_fault, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_in_if.sv
hw/rtl/cbm_out_if.sv
hw/rtl/cbm_ctrl.sv
hw/rtl/cbm_ram.sv
hw/rtl/cartridge_bank_mapper_core.sv
test/tb.sv
